// File: hdl/iqtr_pkg.sv
// Shared types, constants and helpers of the quarter-turn image rotator.
// Used by the frame memory, the register block, the controller and the top level.
package iqtr_pkg;

   localparam int MAX_DIM       = 256;
   localparam int PIXEL_BITS    = 8;
   localparam int IDX_BITS      = $clog2(MAX_DIM);
   localparam int DIM_BITS      = IDX_BITS + 1;
   localparam int ADDR_BITS     = 2 * IDX_BITS;
   localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;

   // Register indexes (byte address is four times the index).
   localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_TURNS  = 2'd2;

   // Rotation codes.
   localparam logic [1:0] TURN_NONE = 2'd0;
   localparam logic [1:0] TURN_CW   = 2'd1;
   localparam logic [1:0] TURN_HALF = 2'd2;
   localparam logic [1:0] TURN_CCW  = 2'd3;

   // Item modes.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [PIXEL_BITS-1:0] pixel_in;
   } req_item_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_out;
      logic [IDX_BITS-1:0]   out_row;
      logic [IDX_BITS-1:0]   out_col;
      logic                  row_end;
      logic                  image_end;
   } rsp_item_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] image_width;
      logic [DIM_BITS-1:0] image_height;
      logic [1:0]          turns_clockwise;
   } cfg_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic [PIXEL_BITS-1:0] wr_data;
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  rd_addr;
   } ram_req_type;

   // A dimension of zero acts as one, any value above the maximum acts as the maximum.
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] res;
      if (v == '0) begin
         res = DIM_BITS'(1);
      end else if (v > DIM_BITS'(MAX_DIM)) begin
         res = DIM_BITS'(MAX_DIM);
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage

// File: hdl/iqtr_frame_ram.sv
// Frame memory of the rotator: one write port, one read port, registered read data.
// Depends on iqtr_pkg for sizes and the request struct.
module iqtr_frame_ram
   import iqtr_pkg::*;
(
   input  logic                  clock,
   input  ram_req_type           ram_req,
   output logic [PIXEL_BITS-1:0] rd_data
);

   logic [PIXEL_BITS-1:0] mem [STORE_DEPTH];
   logic [PIXEL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/iqtr_csr.sv
// Configuration registers of the rotator behind an APB-style port.
// Depends on iqtr_pkg for the register indexes and the configuration struct.
module iqtr_csr
   import iqtr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic [REG_IDX_BITS-1:0] reg_idx;
   logic                    wr_strobe;

   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         unique case (reg_idx)
            REG_WIDTH:  cfg_in.image_width     = csr_pwdata[DIM_BITS-1:0];
            REG_HEIGHT: cfg_in.image_height    = csr_pwdata[DIM_BITS-1:0];
            REG_TURNS:  cfg_in.turns_clockwise = csr_pwdata[1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width     <= DIM_BITS'(1);
         cfg_ff.image_height    <= DIM_BITS'(1);
         cfg_ff.turns_clockwise <= TURN_NONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WIDTH:  csr_prdata = CSR_DATA_BITS'(cfg_ff.image_width);
         REG_HEIGHT: csr_prdata = CSR_DATA_BITS'(cfg_ff.image_height);
         REG_TURNS:  csr_prdata = CSR_DATA_BITS'(cfg_ff.turns_clockwise);
         default:    csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/iqtr_ctrl.sv
// Controller of the rotator: load and read counters, address mapping and output register.
// Depends on iqtr_pkg; drives the frame memory and takes its registered read data.
module iqtr_ctrl
   import iqtr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_item_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_item_type          rsp_item,
   output ram_req_type           ram_req,
   input  logic [PIXEL_BITS-1:0] rd_data
);

   logic [IDX_BITS-1:0] load_row_ff, load_row_in;
   logic [IDX_BITS-1:0] load_col_ff, load_col_in;
   logic [DIM_BITS-1:0] emit_row_ff, emit_row_in;
   logic [IDX_BITS-1:0] emit_col_ff, emit_col_in;
   logic                loaded_ff, loaded_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff;

   logic [DIM_BITS-1:0] w, h, wm1, hm1, ow, oh, owm1, ohm1;
   logic                accept, is_load, emit_live, issue;
   logic [IDX_BITS-1:0] load_row_cur, load_col_cur;
   logic                col_wrap, row_wrap;
   logic [DIM_BITS-1:0] c_wide, src_row, src_col;
   logic [IDX_BITS-1:0] r_idx;
   logic                row_last, img_last;

   assign w    = clamp_dim(cfg.image_width);
   assign h    = clamp_dim(cfg.image_height);
   assign wm1  = w - DIM_BITS'(1);
   assign hm1  = h - DIM_BITS'(1);
   assign ow   = cfg.turns_clockwise[0] ? h : w;
   assign oh   = cfg.turns_clockwise[0] ? w : h;
   assign owm1 = ow - DIM_BITS'(1);
   assign ohm1 = oh - DIM_BITS'(1);

   // A read in flight or a held result blocks the input side.
   assign req_stall = pend_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign is_load   = (req_item.mode == MODE_LOAD);

   // A load after a complete image starts a new one at the origin.
   assign load_row_cur = loaded_ff ? '0 : load_row_ff;
   assign load_col_cur = loaded_ff ? '0 : load_col_ff;
   assign col_wrap     = {1'b0, load_col_cur} >= wm1;
   assign row_wrap     = {1'b0, load_row_cur} >= hm1;

   assign emit_live = loaded_ff && (emit_row_ff < oh);
   assign issue     = accept && !is_load && emit_live;
   assign r_idx     = emit_row_ff[IDX_BITS-1:0];
   assign c_wide    = ({1'b0, emit_col_ff} < ow) ? {1'b0, emit_col_ff} : owm1;
   assign row_last  = c_wide >= owm1;
   assign img_last  = row_last && (emit_row_ff >= ohm1);

   always_comb begin
      unique case (cfg.turns_clockwise)
         TURN_CW: begin
            src_row = hm1 - c_wide;
            src_col = {1'b0, r_idx};
         end
         TURN_HALF: begin
            src_row = hm1 - {1'b0, r_idx};
            src_col = wm1 - c_wide;
         end
         TURN_CCW: begin
            src_row = c_wide;
            src_col = wm1 - {1'b0, r_idx};
         end
         TURN_NONE: begin
            src_row = {1'b0, r_idx};
            src_col = c_wide;
         end
      endcase
   end

   always_comb begin
      ram_req.wr_en   = accept && is_load;
      ram_req.wr_addr = {load_row_cur, load_col_cur};
      ram_req.wr_data = req_item.pixel_in;
      ram_req.rd_en   = issue;
      ram_req.rd_addr = {src_row[IDX_BITS-1:0], src_col[IDX_BITS-1:0]};
   end

   always_comb begin
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      emit_row_in = emit_row_ff;
      emit_col_in = emit_col_ff;
      loaded_in   = loaded_ff;
      if (accept && is_load) begin
         loaded_in   = col_wrap && row_wrap;
         load_col_in = col_wrap ? '0 : load_col_cur + IDX_BITS'(1);
         if (col_wrap) begin
            load_row_in = row_wrap ? '0 : load_row_cur + IDX_BITS'(1);
         end else begin
            load_row_in = load_row_cur;
         end
         if (loaded_ff || (col_wrap && row_wrap)) begin
            emit_row_in = '0;
            emit_col_in = '0;
         end
      end else if (issue) begin
         if (row_last) begin
            emit_col_in = '0;
            emit_row_in = img_last ? oh : emit_row_ff + DIM_BITS'(1);
         end else begin
            emit_col_in = c_wide[IDX_BITS-1:0] + IDX_BITS'(1);
         end
      end
   end

   assign pend_in = issue;

   // The output register is empty whenever read data arrives, see the stall rule.
   always_comb begin
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         emit_row_ff  <= '0;
         emit_col_ff  <= '0;
         loaded_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         emit_row_ff  <= emit_row_in;
         emit_col_ff  <= emit_col_in;
         loaded_ff    <= loaded_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Position flags are captured with the read, the pixel in the cycle after it.
   always_ff @(posedge clock) begin
      if (issue) begin
         rsp_ff.out_row   <= r_idx;
         rsp_ff.out_col   <= c_wide[IDX_BITS-1:0];
         rsp_ff.row_end   <= row_last;
         rsp_ff.image_end <= img_last;
      end
      if (pend_ff) begin
         rsp_ff.pixel_out <= rd_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_pend_into_empty: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !rsp_valid_ff)
      else $error("read data arrived while the output register was occupied");

   a_pend_to_valid: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> rsp_valid_ff)
      else $error("read data did not reach the output");

   a_issue_sets_pend: assert property (@(posedge clock) disable iff (reset)
      issue |=> pend_ff)
      else $error("memory read issued without a pending result");

   a_loaded_at_origin: assert property (@(posedge clock) disable iff (reset)
      loaded_ff |-> (load_row_ff == '0 && load_col_ff == '0))
      else $error("load position not at origin after a complete image");

   a_emit_row_bound: assert property (@(posedge clock) disable iff (reset)
      emit_row_ff <= DIM_BITS'(MAX_DIM))
      else $error("read row beyond the largest image");

endmodule

// File: hdl/image_quarter_turn_rotator_unit.sv
// Top level of the quarter-turn image rotator: registers, controller and frame memory.
// Depends on iqtr_pkg, iqtr_csr, iqtr_ctrl and iqtr_frame_ram.
//
// Load items (mode 0) write pixels in row-major order into a 256 x 256 frame memory; once
// image_height x image_width pixels are in, read items (mode 1) return the image turned by
// turns_clockwise quarter turns, one pixel per item, in row-major order of the turned image.
// A load item writes its pixel into the frame memory. A read item that yields a pixel goes
// through the registered read of the frame memory and then into the output register; the
// input side stalls while that read is in flight, and a held result stalls the input until it
// is taken. Reads before the image is complete or past its last pixel give no item. The
// frame memory has no reset and needs no clearing; change the registers only while idle.
module image_quarter_turn_rotator_unit
   import iqtr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_item_type             req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_item_type             rsp_item,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type               cfg;
   ram_req_type           ram_req;
   logic [PIXEL_BITS-1:0] rd_data;

   iqtr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   iqtr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .ram_req   (ram_req),
      .rd_data   (rd_data)
   );

   iqtr_frame_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

endmodule

// File: bench/tb_image_quarter_turn_rotator_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for image_quarter_turn_rotator_unit: loads random images, reads them back
// turned and compares each pixel, position and end flag with a behavioral copy of the rotation.
// Depends on iqtr_pkg and the rotator RTL.
module tb_image_quarter_turn_rotator_unit;
   import iqtr_pkg::*;

   localparam int ITEM_GOAL     = 1150;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   req_item_type             req_item    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   rsp_item_type             rsp_item;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   image_quarter_turn_rotator_unit uut (.*);

   // Traffic bookkeeping.
   req_item_type pending_items[$];
   rsp_item_type expected_pixels[$];
   int   items_queued   = 0;
   int   items_taken    = 0;
   int   error_count    = 0;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   hold_left      = 0;
   logic req_took       = 1'b0;
   logic long_hold_req  = 1'b0;
   logic long_hold_done = 1'b0;

   // Shadow of the rotator's registers and state.
   logic [DIM_BITS-1:0]   cfg_width  = DIM_BITS'(1);
   logic [DIM_BITS-1:0]   cfg_height = DIM_BITS'(1);
   logic [1:0]            cfg_turns  = TURN_NONE;
   logic [PIXEL_BITS-1:0] frame_copy [STORE_DEPTH];
   int                    load_r     = 0;
   int                    load_c     = 0;
   int                    emit_r     = 0;
   int                    emit_c     = 0;
   bit                    img_ready  = 1'b0;

   // What the stimulus side knows about the image being loaded.
   int gen_pixels = 1;
   int gen_count  = 0;
   bit gen_loaded = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int fit_dim(input logic [DIM_BITS-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   // Advances the shadow by one accepted item and queues the pixel it should produce.
   function automatic void rotate_step(input req_item_type it);
      int w, h, ow, oh, r, c, sr, sc;
      rsp_item_type res;
      w = fit_dim(cfg_width);
      h = fit_dim(cfg_height);
      if (it.mode == MODE_LOAD) begin
         if (img_ready) begin
            img_ready = 1'b0;
            load_r = 0;
            load_c = 0;
            emit_r = 0;
            emit_c = 0;
         end
         frame_copy[(load_r % MAX_DIM) * MAX_DIM + load_c % MAX_DIM] = it.pixel_in;
         if (load_c >= w - 1) begin
            load_c = 0;
            if (load_r >= h - 1) begin
               load_r = 0;
               img_ready = 1'b1;
               emit_r = 0;
               emit_c = 0;
            end else begin
               load_r++;
            end
         end else begin
            load_c++;
         end
      end else if (img_ready) begin
         ow = cfg_turns[0] ? h : w;
         oh = cfg_turns[0] ? w : h;
         if (emit_r < oh) begin
            r = emit_r;
            c = (emit_c < ow) ? emit_c : ow - 1;
            case (cfg_turns)
               TURN_CW: begin
                  sr = h - 1 - c;
                  sc = r;
               end
               TURN_HALF: begin
                  sr = h - 1 - r;
                  sc = w - 1 - c;
               end
               TURN_CCW: begin
                  sr = c;
                  sc = w - 1 - r;
               end
               default: begin
                  sr = r;
                  sc = c;
               end
            endcase
            res.pixel_out = frame_copy[(sr % MAX_DIM) * MAX_DIM + sc % MAX_DIM];
            res.out_row   = IDX_BITS'(r);
            res.out_col   = IDX_BITS'(c);
            res.row_end   = (c >= ow - 1);
            res.image_end = res.row_end && (r >= oh - 1);
            expected_pixels.push_back(res);
            if (res.row_end) begin
               emit_c = 0;
               emit_r = res.image_end ? oh : r + 1;
            end else begin
               emit_c = c + 1;
            end
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
         error_count++;
      end
   endfunction

   // Input side: offers the next pending item once the current one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_item <= pending_items.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Output side stall, with one long hold-off that lets the block back up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (long_hold_req && !long_hold_done) begin
            hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Both handshakes are sampled here; results are checked before the new item is predicted.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("result item arrived with none expected");
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_out", want.pixel_out, rsp_item.pixel_out);
               check_field("out_row", want.out_row, rsp_item.out_row);
               check_field("out_col", want.out_col, rsp_item.out_col);
               check_field("row_end", want.row_end, rsp_item.row_end);
               check_field("image_end", want.image_end, rsp_item.image_end);
            end
         end
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            items_taken++;
            rotate_step(req_item);
         end
      end
   end

   task automatic wait_drain();
      while (items_taken != items_queued || expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_WIDTH: cfg_width = value[DIM_BITS-1:0];
         REG_HEIGHT: cfg_height = value[DIM_BITS-1:0];
         REG_TURNS: cfg_turns = value[1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic configure(input int w_raw, input int h_raw, input logic [1:0] turns);
      wait_drain();
      write_reg(REG_WIDTH, CSR_DATA_BITS'(w_raw));
      write_reg(REG_HEIGHT, CSR_DATA_BITS'(h_raw));
      write_reg(REG_TURNS, CSR_DATA_BITS'(turns));
      gen_pixels = fit_dim(DIM_BITS'(w_raw)) * fit_dim(DIM_BITS'(h_raw));
   endtask

   task automatic push_load(input logic [PIXEL_BITS-1:0] pix);
      req_item_type it;
      it.mode = MODE_LOAD;
      it.pixel_in = pix;
      pending_items.push_back(it);
      items_queued++;
      if (gen_loaded) begin
         gen_loaded = 1'b0;
         gen_count = 0;
      end
      gen_count++;
      if (gen_count == gen_pixels) begin
         gen_loaded = 1'b1;
         gen_count = 0;
      end
   endtask

   task automatic push_read();
      req_item_type it;
      it.mode = MODE_READ;
      it.pixel_in = PIXEL_BITS'($urandom);
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Finishes the image in progress, or loads a whole new one. Stray reads are only mixed in
   // once loading has begun, so they never see the old image under new sizes.
   task automatic load_image(input bit noisy);
      int n;
      n = gen_loaded ? gen_pixels : gen_pixels - gen_count;
      repeat (n) begin
         if (noisy && !gen_loaded && $urandom_range(5) == 0) push_read();
         push_load(PIXEL_BITS'($urandom_range(255)));
      end
   endtask

   task automatic read_image(input int n);
      repeat (n) push_read();
   endtask

   initial begin
      int p, kind, seqs;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset sizes are one by one: read before loading, read past the end, reload.
      push_read();
      push_load(8'h00);
      push_read();
      push_read();
      push_load(8'hFF);
      push_read();

      // A three by two image turned clockwise, with one read past its end.
      configure(3, 2, TURN_CW);
      push_load(8'h00);
      push_load(8'h01);
      push_load(8'h80);
      push_load(8'h7F);
      push_load(8'hFF);
      push_load(8'h55);
      read_image(7);

      p = 0;
      while (items_queued < ITEM_GOAL || p < 5) begin
         // Sizes only change with a complete image in the store.
         if (!gen_loaded) load_image(1'b0);
         if (p == 1) begin
            // Widest image, one row high, written through the clamped register values.
            configure(511, 0, TURN_CW);
         end else begin
            configure($urandom_range(0, 9), $urandom_range(0, 9), 2'((p + p / 4) % 4));
         end
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 64;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 64;
            end
            default: begin
               send_idle_pct = 19;
               recv_stall_pct = 19;
            end
         endcase
         if (p == 4) long_hold_req = 1'b1;
         if (p == 1) begin
            load_image(1'b0);
            read_image(gen_pixels + 1);
         end else begin
            seqs = $urandom_range(3, 6);
            repeat (seqs) begin
               kind = $urandom_range(9);
               if (kind == 9) begin
                  // Loading that may stop short of a full image, then reads that the block ignores in that case.
                  repeat ($urandom_range(1, gen_pixels)) push_load(PIXEL_BITS'($urandom_range(255)));
                  repeat ($urandom_range(1, 3)) push_read();
               end else begin
                  load_image(kind == 8);
                  if (kind == 7) read_image($urandom_range(1, gen_pixels));
                  else read_image(gen_pixels + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0));
               end
               if ($urandom_range(4) == 0) wait_drain();
            end
         end
         p++;
      end

      wait_drain();
      if (error_count == 0) begin
         $display("[image_quarter_turn_rotator_unit] OK");
      end else begin
         $display("[image_quarter_turn_rotator_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[image_quarter_turn_rotator_unit] ERROR");
      $finish;
   end

endmodule
